// ----- hdl/xcfp_pkg.sv -----
package xcfp_pkg;

    // byte and field widths of the stream payload
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int OUT_TDATA_W = 16;
    localparam int IN_TDATA_W  = 8;

    // defaults
    localparam int              PAYLOAD_DEPTH_DEF = 64;
    localparam logic [BYTE_W-1:0] SYNC_RESET      = 8'hB6;

    // start command from the parser to the payload emitter
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] len;
    } t_drain_cmd;

endpackage

// ----- hdl/xor_checked_frame_parser_core.sv -----
// Channel   | Dir | Beat contents (low bit first)                 | Side info
// ----------+-----+-----------------------------------------------+-----------------------
// s_axis    | in  | tdata[7:0] rx_byte                            | none
// m_axis    | out | tdata[7:0] payload_byte, [13:8] byte_index    | tlast = last_byte
// cfg       | in  | wr_data[7:0] sync_byte                        | written when wr_en high
//
// Input beats are taken one per cycle while hunting and receiving a frame.
// After a matching checksum, s_axis_tready stays low until the last payload
// byte has been read into the output register: each payload byte takes a
// store read, then an output register load, and with a single outstanding
// read of the payload store the next read waits until the last has landed.
// Synchronous active-low reset returns to sync hunting; the store is not cleared.
// Output backpressure only stretches the drain; the output register holds the beat.
module xor_checked_frame_parser_core
    import xcfp_pkg::*;
    #(
        parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
    )
    (
        input  logic                   i_clk,
        input  logic                   i_rst_n,
        // config
        input  logic                   i_cfg_wr_en,
        input  logic [BYTE_W-1:0]      i_cfg_wr_data,   // [7:0] sync_byte
        // receive stream
        input  logic                   i_s_axis_tvalid,
        output logic                   o_s_axis_tready,
        input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
        // payload stream
        output logic                   o_m_axis_tvalid,
        input  logic                   i_m_axis_tready,
        output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // [7:0] payload_byte, [13:8] byte_index
        output logic                   o_m_axis_tlast
    );

    localparam int LEN_W = $clog2(PAYLOAD_DEPTH + 1);
    localparam int AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    // parse phases
    localparam logic [1:0] PH_SYNC  = 2'd0;
    localparam logic [1:0] PH_LEN   = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [BYTE_W-1:0] r_sync;
    logic [1:0]        r_phase, n_phase;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_xor, n_xor;

    logic              acc;
    logic [BYTE_W-1:0] rx;
    logic [LEN_W-1:0]  cnt_inc;
    logic              len_bad;
    logic              csum_ok;
    logic              emit_busy;
    t_drain_cmd        drain_cmd;

    logic              st_wr_en;
    logic [AW-1:0]     st_rd_addr;
    logic              st_rd_en;
    logic [BYTE_W-1:0] st_rd_data;
    logic [BYTE_W-1:0] out_byte;
    logic [IDX_W-1:0]  out_idx;

    assign o_s_axis_tready = !emit_busy;
    assign acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign rx      = i_s_axis_tdata[BYTE_W-1:0];
    assign cnt_inc = LEN_W'(r_cnt + 1'b1);
    assign len_bad = (rx == '0) || (rx > BYTE_W'(PAYLOAD_DEPTH));
    assign csum_ok = (rx == r_xor);

    // frame parser
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_xor   = r_xor;
        if (acc) begin
            unique case (r_phase)
                PH_SYNC: begin
                    if (rx == r_sync) begin
                        n_xor   = rx;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (len_bad) begin
                        n_phase = PH_SYNC;
                    end else begin
                        n_len   = rx[LEN_W-1:0];
                        n_cnt   = '0;
                        n_xor   = r_xor ^ rx;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_xor = r_xor ^ rx;
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_len) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_SYNC;
                end
                default: begin
                    n_phase = PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync  <= SYNC_RESET;
            r_phase <= PH_SYNC;
            r_len   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_sync <= i_cfg_wr_data;
            end
            r_phase <= n_phase;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
        end
    end

    // payload bytes go straight into the store at the running count
    assign st_wr_en = acc && (r_phase == PH_DATA);

    assign drain_cmd.start = acc && (r_phase == PH_CHECK) && csum_ok;
    assign drain_cmd.len   = BYTE_W'(r_len);

    xcfp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (rx),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data)
    );

    xcfp_emit #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (drain_cmd),
        .o_busy    (emit_busy),
        .o_rd_en   (st_rd_en),
        .o_rd_addr (st_rd_addr),
        .i_rd_data (st_rd_data),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_byte    (out_byte),
        .o_idx     (out_idx),
        .o_tlast   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - BYTE_W - IDX_W){1'b0}}, out_idx, out_byte};

    // a matched checksum must start the drain
    a_match_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_cmd.start |=> emit_busy)
        else $error("core: checksum match did not start drain");

    // a stored length is always legal once past the length byte
    a_len_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA || r_phase == PH_CHECK) |->
            (r_len != '0 && r_len <= LEN_W'(PAYLOAD_DEPTH)))
        else $error("core: illegal frame length held");

    // the store write pointer stays inside the frame
    a_cnt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_cnt < r_len))
        else $error("core: payload count ran past frame length");

    // the store is never written while it is being drained
    a_no_wr_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_busy |-> !st_wr_en)
        else $error("core: store written during drain");

endmodule

// ----- hdl/xcfp_ram.sv -----
module xcfp_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 64,
        localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             i_clk,
        input  logic             i_wr_en,
        input  logic [AW-1:0]    i_wr_addr,
        input  logic [WIDTH-1:0] i_wr_data,
        input  logic             i_rd_en,
        input  logic [AW-1:0]    i_rd_addr,
        output logic [WIDTH-1:0] o_rd_data
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/xcfp_emit.sv -----
module xcfp_emit
    import xcfp_pkg::*;
    #(
        parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
        localparam int LEN_W        = $clog2(PAYLOAD_DEPTH + 1),
        localparam int AW           = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
    )
    (
        input  logic              i_clk,
        input  logic              i_rst_n,
        input  t_drain_cmd        i_cmd,
        output logic              o_busy,
        // store read port
        output logic              o_rd_en,
        output logic [AW-1:0]     o_rd_addr,
        input  logic [BYTE_W-1:0] i_rd_data,
        // result beat
        output logic              o_tvalid,
        input  logic              i_tready,
        output logic [BYTE_W-1:0] o_byte,
        output logic [IDX_W-1:0]  o_idx,
        output logic              o_tlast
    );

    logic [LEN_W-1:0]  r_left, n_left;
    logic [AW-1:0]     r_addr, n_addr;
    logic              r_pend;
    logic [AW-1:0]     r_pend_addr;
    logic              r_pend_last;
    logic              r_tvalid, n_tvalid;
    logic [BYTE_W-1:0] r_byte;
    logic [IDX_W-1:0]  r_idx;
    logic              r_tlast;
    logic              rd_issue;
    logic [AW+IDX_W-1:0] pend_ext;

    // one read in flight at a time; issue only when the output reg is free next cycle
    assign rd_issue = (r_left != '0) && !r_pend && (!r_tvalid || i_tready);
    assign pend_ext = {{IDX_W{1'b0}}, r_pend_addr};

    always_comb begin
        n_left   = r_left;
        n_addr   = r_addr;
        n_tvalid = r_tvalid;
        if (i_cmd.start) begin
            n_left = i_cmd.len[LEN_W-1:0];
            n_addr = '0;
        end else if (rd_issue) begin
            n_left = LEN_W'(r_left - 1'b1);
            n_addr = AW'(r_addr + 1'b1);
        end
        if (r_pend) begin
            n_tvalid = 1'b1;
        end else if (i_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_addr   <= '0;
            r_pend   <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_addr   <= n_addr;
            r_pend   <= rd_issue;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_pend_addr <= r_addr;
            r_pend_last <= (r_left == LEN_W'(1));
        end
        if (r_pend) begin
            r_byte  <= i_rd_data;
            r_idx   <= pend_ext[IDX_W-1:0];
            r_tlast <= r_pend_last;
        end
    end

    assign o_busy    = (r_left != '0) || r_pend;
    assign o_rd_en   = rd_issue;
    assign o_rd_addr = r_addr;
    assign o_tvalid  = r_tvalid;
    assign o_byte    = r_byte;
    assign o_idx     = r_idx;
    assign o_tlast   = r_tlast;

    // read data must never land on an unconsumed beat
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(!r_tvalid || i_tready))
        else $error("emit: read data arrived while output beat still held");

    // no read of the same frame is still in flight behind the last beat;
    // the next frame may already be loaded while it waits
    a_last_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tvalid && r_tlast) |-> !r_pend)
        else $error("emit: last beat shown with a read outstanding");

    // a new frame never starts on top of a drain
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> !o_busy)
        else $error("emit: start while busy");

endmodule

// ----- tb/sv/xcfp_frame_check_pkg.sv -----
package xcfp_frame_check_pkg;

    import xcfp_pkg::*;

    localparam int PAYLOAD_CAP = PAYLOAD_DEPTH_DEF;

    typedef enum logic [1:0] {
        HUNT_SYNC,
        GET_LEN,
        GET_PAYLOAD,
        GET_CHECK
    } t_frame_stage;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  byte_index;
        logic              last_byte;
    } t_payload_beat;

    // Frame parser predictor plus the queue of payload beats it still owes.
    class t_frame_payload_sb;

        t_frame_stage      stage;
        logic [BYTE_W-1:0] sync_byte;
        logic [BYTE_W-1:0] running_xor;
        logic [6:0]        frame_len;
        logic [6:0]        rx_count;
        logic [BYTE_W-1:0] payload_mem [PAYLOAD_CAP];
        t_payload_beat     expected_q [$];
        int                n_fail;

        function new();
            stage       = HUNT_SYNC;
            sync_byte   = SYNC_RESET;
            running_xor = '0;
            frame_len   = '0;
            rx_count    = '0;
            n_fail      = 0;
            foreach (payload_mem[i]) payload_mem[i] = '0;
        endfunction

        function void set_sync(logic [BYTE_W-1:0] value);
            sync_byte = value;
        endfunction

        // one accepted rx beat
        function void note_rx_byte(logic [BYTE_W-1:0] b);
            t_payload_beat beat;
            case (stage)
                HUNT_SYNC: begin
                    if (b == sync_byte) begin
                        running_xor = b;
                        stage       = GET_LEN;
                    end
                end
                GET_LEN: begin
                    if (b == 0 || int'(b) > PAYLOAD_CAP) begin
                        stage = HUNT_SYNC;
                    end else begin
                        frame_len   = 7'(b);
                        rx_count    = '0;
                        running_xor = running_xor ^ b;
                        stage       = GET_PAYLOAD;
                    end
                end
                GET_PAYLOAD: begin
                    if (int'(rx_count) < PAYLOAD_CAP) payload_mem[rx_count] = b;
                    running_xor = running_xor ^ b;
                    rx_count    = rx_count + 7'd1;
                    if (rx_count >= frame_len) stage = GET_CHECK;
                end
                default: begin
                    if (b == running_xor) begin
                        for (int k = 0; k < int'(frame_len) && k < PAYLOAD_CAP; k++) begin
                            beat.payload_byte = payload_mem[k];
                            beat.byte_index   = IDX_W'(k);
                            beat.last_byte    = (k + 1 == int'(frame_len));
                            expected_q.push_back(beat);
                        end
                    end
                    stage = HUNT_SYNC;
                end
            endcase
        endfunction

        // one accepted payload beat from the block
        function void check_payload_beat(logic [BYTE_W-1:0] pb, logic [IDX_W-1:0] idx,
                                         logic lb);
            t_payload_beat want;
            if (expected_q.size() == 0) begin
                $error("unexpected payload beat: payload_byte=0x%02h byte_index=%0d last_byte=%0b",
                       pb, idx, lb);
                n_fail++;
                return;
            end
            want = expected_q.pop_front();
            if (pb !== want.payload_byte) begin
                $error("payload_byte: expected 0x%02h, got 0x%02h", want.payload_byte, pb);
                n_fail++;
            end
            if (idx !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, idx);
                n_fail++;
            end
            if (lb !== want.last_byte) begin
                $error("last_byte: expected %0b, got %0b", want.last_byte, lb);
                n_fail++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sv/xor_checked_frame_parser_core_tb.sv -----
module xor_checked_frame_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import xcfp_pkg::*;
    import xcfp_frame_check_pkg::*;

    // run control
    localparam int  HALF_PERIOD   = 6;
    localparam int  LONG_HOLD     = 200;       // sink hold-off, cycles
    localparam int  SETTLE_CYCLES = 8;         // quiet time before a sync write
    localparam int  DRAIN_LIMIT   = 20000;     // end-of-run wait bound, cycles
    localparam int  TAIL_CYCLES   = 20;
    localparam int  PHASE_BEATS   = 3;         // random rx beats per sync setting, at least
    localparam time WATCHDOG_NS   = 2_000_000;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_wr_en     = 1'b0;
    logic [BYTE_W-1:0]      i_cfg_wr_data   = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;    // [7:0] rx_byte
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;          // [7:0] payload_byte, [13:8] byte_index
    logic                   o_m_axis_tlast;

    t_frame_payload_sb payload_sb = new();

    // shared between the source and sink processes; each var has one writer
    logic [BYTE_W-1:0] cur_sync    = SYNC_RESET;  // source
    bit                calm        = 1'b0;        // source: no idling from here on
    bit                tx_idle_on  = 1'b1;        // source: gaps allowed for this frame
    int                n_sent      = 0;           // source: accepted rx beats
    int                hold_req    = 0;           // source: bumps to ask for a long hold
    int                hold_served = 0;           // sink

    xor_checked_frame_parser_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Source side. Everything is driven at the falling edge; a beat counts
    // as taken at the rising edge where tvalid and tready are both high.
    // On return the task sits at the falling edge after the handshake with
    // tvalid still up, so the next call either swaps data or drops tvalid
    // before the following rising edge.
    // ------------------------------------------------------------------
    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (!calm && tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap             = $urandom_range(1, 6);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        payload_sb.note_rx_byte(b);
        n_sent++;
        @(negedge i_clk);
    endtask

    // sync, length, payload, checksum; a zero or oversize length stops after
    // the length beat since the parser is back to hunting by then
    task automatic send_frame(input logic [BYTE_W-1:0] len_byte, input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] pb;
        sum = cur_sync ^ len_byte;
        send_rx_byte(cur_sync);
        send_rx_byte(len_byte);
        if (len_byte != 0 && int'(len_byte) <= PAYLOAD_CAP) begin
            for (int k = 0; k < int'(len_byte); k++) begin
                pb  = BYTE_W'($urandom);
                sum = sum ^ pb;
                send_rx_byte(pb);
            end
            // corrupt by a nonzero mask so the check can't match by chance
            send_rx_byte(bad_sum ? (sum ^ BYTE_W'($urandom_range(1, 255))) : sum);
        end
    endtask

    // Stop offering and let every owed payload beat come out. A dropped frame
    // owes nothing, so give the block a few extra cycles to settle as well.
    task automatic wait_all_drained();
        i_s_axis_tvalid = 1'b0;
        while (payload_sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // sync register write; only called with the block idle
    task automatic write_sync(input logic [BYTE_W-1:0] value);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        @(posedge i_clk);
        payload_sb.set_sync(value);
        cur_sync = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [BYTE_W-1:0] sync_plan [4];
        logic [BYTE_W-1:0] len_byte;
        int                phase_end;
        int                pick;
        int                wait_cnt;

        // sync setting per random phase: both extremes, one arbitrary, default
        sync_plan = '{8'h00, 8'hFF, BYTE_W'($urandom_range(1, 254)), SYNC_RESET};

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // --- directed, default sync 0xB6 ---
        // noise while hunting is ignored
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        // zero length, one past the store size, and the largest length byte
        send_frame(8'd0, 1'b0);
        send_frame(8'd65, 1'b0);
        send_frame(8'hFF, 1'b0);
        // single 0xFF payload byte, good check (B6^01^FF)
        send_rx_byte(SYNC_RESET);
        send_rx_byte(8'h01);
        send_rx_byte(8'hFF);
        send_rx_byte(8'h48);
        // sync value inside the payload is plain data
        send_rx_byte(SYNC_RESET);
        send_rx_byte(8'h02);
        send_rx_byte(SYNC_RESET);
        send_rx_byte(8'h00);
        send_rx_byte(8'h02);
        // bad checksum: nothing comes out
        send_rx_byte(SYNC_RESET);
        send_rx_byte(8'h01);
        send_rx_byte(8'h55);
        send_rx_byte(8'hE3);
        // zero payload byte, good check
        send_rx_byte(SYNC_RESET);
        send_rx_byte(8'h01);
        send_rx_byte(8'h00);
        send_rx_byte(8'hB7);

        // --- random phases, one per sync setting ---
        foreach (sync_plan[p]) begin
            wait_all_drained();
            write_sync(sync_plan[p]);
            calm = (p == 3);

            if (p == 0) begin
                // full store: byte_index runs to 63
                send_frame(8'd64, 1'b0);
            end
            if (p == 1) begin
                // sink stalls for a long stretch while frames keep arriving,
                // so the drain backs up into the rx side
                hold_req++;
                send_frame(8'd4, 1'b0);
                send_frame(8'd2, 1'b0);
            end

            phase_end = n_sent + PHASE_BEATS;
            while (n_sent < phase_end) begin
                tx_idle_on = ($urandom_range(0, 2) != 0);
                pick       = $urandom_range(0, 99);
                if (pick < 80) begin
                    // mostly short frames, now and then a medium one
                    pick = $urandom_range(0, 99);
                    if (pick < 85) len_byte = BYTE_W'($urandom_range(1, 6));
                    else           len_byte = BYTE_W'($urandom_range(7, 20));
                    send_frame(len_byte, $urandom_range(0, 7) == 0);
                end else if (pick < 90) begin
                    len_byte = ($urandom_range(0, 1) == 0) ? 8'd0
                                                           : BYTE_W'($urandom_range(65, 255));
                    send_frame(len_byte, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 4)) send_rx_byte(BYTE_W'($urandom));
                end
            end
        end

        // --- wind down ---
        i_s_axis_tvalid = 1'b0;
        wait_cnt        = 0;
        while (payload_sb.expected_q.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (payload_sb.expected_q.size() != 0) begin
            $error("%0d expected payload beats never arrived", payload_sb.expected_q.size());
            payload_sb.n_fail++;
        end

        if (payload_sb.n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink side: random tready bursts, a long hold on request, and steady
    // ready once the source goes calm. The hold request is polled every
    // cycle of a ready run, so the hold lands while the requested frames are in flight.
    // ------------------------------------------------------------------
    initial begin : payload_sink
        int run;
        @(negedge i_clk);
        forever begin
            if (hold_req != hold_served) begin
                i_m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_served = hold_req;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                run             = $urandom_range(1, 6);
                i_m_axis_tready = 1'b0;
                repeat (run) @(negedge i_clk);
            end else begin
                run             = $urandom_range(1, 12);
                i_m_axis_tready = 1'b1;
                repeat (run) begin
                    if (hold_req != hold_served) break;
                    @(negedge i_clk);
                end
            end
        end
    end

    // output beats are checked at the rising edge they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            payload_sb.check_payload_beat(o_m_axis_tdata[BYTE_W-1:0],
                                          o_m_axis_tdata[BYTE_W+IDX_W-1:BYTE_W],
                                          o_m_axis_tlast);
        end
    end

    // hard stop if the run hangs
    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
